/* design/compact_index_codec_defines.svh */
// ----------------------------------------------------------------------------
// Compact index codec assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef COMPACT_INDEX_CODEC_DEFINES_SVH
`define COMPACT_INDEX_CODEC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("compact index codec check failed");

// The consequent must hold in the cycle after the antecedent.
`define CIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("compact index codec check failed");

`endif

/* design/cic_pkg.sv */
// ----------------------------------------------------------------------------
// Compact index codec package
// Types and constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package cic_pkg;

	localparam int MAG_W = 31;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MAG_W-1:0] MAG_MAX = 31'h7fffffff;
	localparam logic [MAG_W-1:0] LIM_ONE = 31'h0000003f;
	localparam logic [MAG_W-1:0] LIM_TWO = 31'h00001fff;
	localparam logic [MAG_W-1:0] LIM_THREE = 31'h000fffff;
	localparam logic [MAG_W-1:0] LIM_FOUR = 31'h07ffffff;

	typedef logic [2:0] pos_t;

	localparam pos_t POS_FIRST = 3'd0;
	localparam pos_t POS_SECOND = 3'd1;
	localparam pos_t POS_THIRD = 3'd2;
	localparam pos_t POS_FOURTH = 3'd3;
	localparam pos_t POS_FIFTH = 3'd4;

	typedef struct packed {
		logic             decode;
		logic             sign;
		logic [MAG_W-1:0] mag;
		pos_t             last_pos;
		logic [7:0]       code_byte;
	} cic_entry_t;

endpackage

/* design/cic_cfg_if.sv */
// ----------------------------------------------------------------------------
// Compact index codec configuration channel
// Carries writes of the mode register.
// ----------------------------------------------------------------------------
interface cic_cfg_if;
	logic valid;
	logic ready;
	logic decode_mode;

	modport source (output valid, output decode_mode, input ready);
	modport sink (input valid, input decode_mode, output ready);
endinterface

/* design/cic_in_if.sv */
// ----------------------------------------------------------------------------
// Compact index codec input channel
// Carries a value to encode or a byte to decode.
// ----------------------------------------------------------------------------
interface cic_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] in_value;
	logic [7:0]         in_byte;

	modport source (output valid, output in_value, output in_byte, input ready);
	modport sink (input valid, input in_value, input in_byte, output ready);
endinterface

/* design/cic_out_if.sv */
// ----------------------------------------------------------------------------
// Compact index codec output channel
// Carries an encoded byte or a decoded value.
// ----------------------------------------------------------------------------
interface cic_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         out_byte;
	logic               out_last;
	logic signed [31:0] out_value;

	modport source (output valid, output out_byte, output out_last, output out_value,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input out_value,
		output ready);
endinterface

/* design/cic_front.sv */
// ----------------------------------------------------------------------------
// Compact index codec front end
// Accepts input transactions and classifies them into queue entries.
// ----------------------------------------------------------------------------
module cic_front import cic_pkg::*; (
	input  logic       decode_mode,
	cic_in_if.sink     item,
	input  logic       q_full,
	output logic       push,
	output cic_entry_t entry
);

	logic        neg;
	logic [31:0] abs_val;
	logic [MAG_W-1:0] mag;
	pos_t        last_pos;

	always_comb begin
		neg = item.in_value[31];
		abs_val = neg ? 32'(-item.in_value) : 32'(item.in_value);
		mag = abs_val[31] ? MAG_MAX : abs_val[MAG_W-1:0];
		if (mag <= LIM_ONE) begin
			last_pos = POS_FIRST;
		end else if (mag <= LIM_TWO) begin
			last_pos = POS_SECOND;
		end else if (mag <= LIM_THREE) begin
			last_pos = POS_THIRD;
		end else if (mag <= LIM_FOUR) begin
			last_pos = POS_FOURTH;
		end else begin
			last_pos = POS_FIFTH;
		end
	end

	assign item.ready = !q_full;
	assign push = item.valid && !q_full;

	always_comb begin
		entry.decode = decode_mode;
		entry.sign = neg;
		entry.mag = mag;
		entry.last_pos = last_pos;
		entry.code_byte = item.in_byte;
	end

endmodule

/* design/cic_queue.sv */
// ----------------------------------------------------------------------------
// Compact index codec queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cic_queue import cic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cic_entry_t push_entry,
	input  logic       pop,
	output logic       full,
	output logic       head_valid,
	output cic_entry_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cic_entry_t       entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/cic_back.sv */
// ----------------------------------------------------------------------------
// Compact index codec back end
// Emits encoded bytes one per cycle while the output is ready, or accumulates bytes into values.
// ----------------------------------------------------------------------------
module cic_back import cic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       head_valid,
	input  cic_entry_t head,
	output logic       pop,
	cic_out_if.source  result
);

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic [31:0]      out_value_q;

	pos_t             enc_pos_q;
	pos_t             dec_pos_q;
	logic [MAG_W-1:0] acc_q;
	logic             sign_q;

	logic             load_ok;
	logic             enc_last;
	logic [7:0]       enc_byte;
	logic [7:0]       b;
	logic [MAG_W-1:0] new_acc;
	logic             new_sign;
	logic             done;
	logic [31:0]      dec_value;
	logic             emit;

	assign load_ok = !out_valid_q || result.ready;

	always_comb begin
		enc_last = (enc_pos_q == head.last_pos);
		case (enc_pos_q)
			POS_FIRST: enc_byte = {!enc_last, head.sign, head.mag[5:0]};
			POS_SECOND: enc_byte = {!enc_last, head.mag[12:6]};
			POS_THIRD: enc_byte = {!enc_last, head.mag[19:13]};
			POS_FOURTH: enc_byte = {!enc_last, head.mag[26:20]};
			default: enc_byte = {4'b0, head.mag[30:27]};
		endcase
	end

	always_comb begin
		b = head.code_byte;
		new_sign = sign_q;
		done = !b[7];
		case (dec_pos_q)
			POS_FIRST: begin
				new_sign = b[6];
				new_acc = {25'b0, b[5:0]};
			end
			POS_SECOND: new_acc = acc_q | {18'b0, b[6:0], 6'b0};
			POS_THIRD: new_acc = acc_q | {11'b0, b[6:0], 13'b0};
			POS_FOURTH: new_acc = acc_q | {4'b0, b[6:0], 20'b0};
			default: begin
				new_acc = acc_q | {b[3:0], 27'b0};
				done = 1'b1;
			end
		endcase
		dec_value = new_sign ? 32'(-{1'b0, new_acc}) : {1'b0, new_acc};
	end

	always_comb begin
		if (head.decode) begin
			emit = head_valid && load_ok && done;
			pop = head_valid && (load_ok || !done);
		end else begin
			emit = head_valid && load_ok;
			pop = head_valid && load_ok && enc_last;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= head.decode ? 8'h00 : enc_byte;
			out_last_q <= head.decode ? 1'b0 : enc_last;
			out_value_q <= head.decode ? dec_value : 32'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			enc_pos_q <= POS_FIRST;
			dec_pos_q <= POS_FIRST;
			acc_q <= '0;
			sign_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= emit;
			end
			if (head_valid && !head.decode && load_ok) begin
				enc_pos_q <= enc_last ? POS_FIRST : enc_pos_q + 1'b1;
			end
			if (clear) begin
				dec_pos_q <= POS_FIRST;
				acc_q <= '0;
				sign_q <= 1'b0;
			end else if (head.decode && pop) begin
				if (done) begin
					dec_pos_q <= POS_FIRST;
					acc_q <= '0;
					sign_q <= 1'b0;
				end else begin
					dec_pos_q <= dec_pos_q + 1'b1;
					acc_q <= new_acc;
					sign_q <= new_sign;
				end
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.out_last = out_last_q;
	assign result.out_value = out_value_q;

endmodule

/* design/compact_index_codec.sv */
// Decode mode takes one byte per cycle; a value appears when its last byte arrives.
// Only a last byte waits while the output is stalled; the others are still taken.
// Encode mode sends one byte per cycle while the output is ready, 1 to 5 per value.
// The two-entry queue lets the front end take items while the back end emits bytes.
// Reset is asynchronous and active low; it selects encode mode and clears all state but the data registers.
// ----------------------------------------------------------------------------
// Compact index codec
// Encodes signed values into compact index bytes or decodes them back.
// ----------------------------------------------------------------------------
module compact_index_codec import cic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cic_cfg_if.sink    cfg,
	cic_in_if.sink     item,
	cic_out_if.source  result
);

	logic       mode_q;
	logic       cfg_write;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       head_valid;
	cic_entry_t push_entry;
	cic_entry_t head;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_write) begin
			mode_q <= cfg.decode_mode;
		end
	end

	cic_front u_front (
		.decode_mode (mode_q),
		.item        (item),
		.q_full      (q_full),
		.push        (push),
		.entry       (push_entry)
	);

	cic_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	cic_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_write),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* design/cic_checker.sv */
// ----------------------------------------------------------------------------
// Compact index codec checker
// Port-level checks on output transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "compact_index_codec_defines.svh"

module cic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        out_last,
	input logic [31:0] out_value
);

	`CIC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_value))
	`CIC_ASSERT_SAME(a_value_no_byte, clk, arst_n, out_valid && (out_value != 32'h0), (out_byte == 8'h00) && !out_last)
	`CIC_ASSERT_SAME(a_byte_no_value, clk, arst_n, out_valid && (out_byte != 8'h00), out_value == 32'h0)
	`CIC_ASSERT_SAME(a_value_range, clk, arst_n, out_valid, out_value != 32'h80000000)

endmodule

bind compact_index_codec cic_checker u_cic_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_byte  (result.out_byte),
	.out_last  (result.out_last),
	.out_value (result.out_value)
);
